// ===== sv/bste_pkg.sv =====
// ----------------------------------------------------------------------------
// bste_pkg
// Types and constants shared by the banded star triple enumerator files.
// ----------------------------------------------------------------------------
package bste_pkg;

    // Operation codes carried in the input transfer.
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESET   = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;
    localparam logic [1:0] OP_BANDED  = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_STAR_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH = 2'd1;

    localparam logic [CFG_DATA_W-1:0] STAR_COUNT_RST = 11'd3;
    localparam logic [CFG_DATA_W-1:0] BAND_WIDTH_RST = 11'd16;

    localparam int ENERGY_W = 32;

    typedef struct packed {
        logic [1:0]          operation;
        logic [9:0]          address;
        logic [ENERGY_W-1:0] energy;
        logic [ENERGY_W-1:0] limit;
    } bste_in_t;

    typedef struct packed {
        logic [9:0] first_index;
        logic [9:0] second_index;
        logic [9:0] third_index;
        logic       exhausted;
    } bste_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BAND,
        ST_BAND_DIM,
        ST_ADV_T,
        ST_ADV_T_CMP,
        ST_ADV_S,
        ST_ADV_S_CMP,
        ST_ADV_F,
        ST_ADV_F_CMP,
        ST_ADV_FAIL,
        ST_BAND_BRT,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_SRCH_END,
        ST_RESP
    } bste_state_t;

endpackage

// ===== sv/banded_star_triple_enumerator.sv =====
// ----------------------------------------------------------------------------
// banded_star_triple_enumerator
// Walks index triples over a table of star energies held in one RAM.
// ----------------------------------------------------------------------------
// Operations: load, advance, reset to a bright limit and banded step. Items are
// handled one at a time; the next item can be taken the cycle after the result
// is registered. Each table probe issues an address on the single RAM read port
// and uses the registered read data in the following state.
// Reset (aresetn low, synchronous) clears the control state and the triple;
// the energy table is not cleared and holds nothing until loaded.
// ----------------------------------------------------------------------------
module banded_star_triple_enumerator #(
    parameter int MAX_STARS = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bste_pkg::bste_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bste_pkg::bste_out_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bste_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bste_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W = $clog2(MAX_STARS);
    localparam int CW = (IDX_W + 2 > 13) ? IDX_W + 2 : 13;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_STARS);

    bste_pkg::bste_state_t state_reg, state_next;

    logic [IDX_W-1:0] first_reg, first_next;
    logic [IDX_W-1:0] second_reg, second_next;
    logic [IDX_W-1:0] third_reg, third_next;
    logic             done_reg, done_next;
    logic             banded_reg, banded_next;
    logic [bste_pkg::ENERGY_W-1:0] limit_reg, limit_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [bste_pkg::CFG_DATA_W-1:0] star_count_reg;
    logic [bste_pkg::CFG_DATA_W-1:0] band_width_reg;
    logic             m_valid_reg;
    bste_pkg::bste_out_t m_data_reg;

    logic [CW-1:0] n_c, bw_c, sc_c, bwr_c;
    logic [CW-1:0] first_c, second_c, third_c;
    logic [CW-1:0] band_idx, half, mid, addr_c;
    logic          accept, out_free;
    logic          ram_wr_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [bste_pkg::ENERGY_W-1:0] ram_rd_data;
    logic          hit;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign hit      = ram_rd_data >= limit_reg;

    // Registers saturated to the ranges that the walk assumes.
    assign sc_c  = CW'(star_count_reg);
    assign bwr_c = CW'(band_width_reg);
    assign n_c   = (sc_c < CW'(3)) ? CW'(3) : ((sc_c > MAX_C) ? MAX_C : sc_c);
    assign bw_c  = (bwr_c < CW'(3)) ? CW'(3) : bwr_c;

    assign first_c  = CW'(first_reg);
    assign second_c = CW'(second_reg);
    assign third_c  = CW'(third_reg);
    assign band_idx = first_c + bw_c;
    assign half     = cnt_reg >> 1;
    assign mid      = lo_reg + half;
    assign addr_c   = CW'(s_data.address);

    bste_ram #(
        .WIDTH (bste_pkg::ENERGY_W),
        .DEPTH (MAX_STARS)
    ) u_energy_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (addr_c[IDX_W-1:0]),
        .wr_data (s_data.energy),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bste_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.operation)
                        bste_pkg::OP_LOAD:    state_next = bste_pkg::ST_RESP;
                        bste_pkg::OP_RESET:   state_next = bste_pkg::ST_SRCH;
                        bste_pkg::OP_ADVANCE: state_next = done_reg ? bste_pkg::ST_RESP
                                                                    : bste_pkg::ST_ADV_T;
                        bste_pkg::OP_BANDED:  state_next = done_reg ? bste_pkg::ST_RESP
                                                                    : bste_pkg::ST_BAND;
                        default:              state_next = bste_pkg::ST_RESP;
                    endcase
                end
            end
            bste_pkg::ST_BAND: begin
                state_next = (band_idx < n_c) ? bste_pkg::ST_BAND_DIM : bste_pkg::ST_ADV_T;
            end
            bste_pkg::ST_BAND_DIM: state_next = bste_pkg::ST_ADV_T;
            bste_pkg::ST_ADV_T: begin
                state_next = (third_c + CW'(1) < n_c) ? bste_pkg::ST_ADV_T_CMP
                                                      : bste_pkg::ST_ADV_S;
            end
            bste_pkg::ST_ADV_T_CMP: state_next = hit ? bste_pkg::ST_RESP : bste_pkg::ST_ADV_S;
            bste_pkg::ST_ADV_S: begin
                state_next = (second_c + CW'(2) < n_c) ? bste_pkg::ST_ADV_S_CMP
                                                       : bste_pkg::ST_ADV_F;
            end
            bste_pkg::ST_ADV_S_CMP: state_next = hit ? bste_pkg::ST_RESP : bste_pkg::ST_ADV_F;
            bste_pkg::ST_ADV_F: begin
                state_next = (first_c + CW'(3) < n_c) ? bste_pkg::ST_ADV_F_CMP
                                                      : bste_pkg::ST_ADV_FAIL;
            end
            bste_pkg::ST_ADV_F_CMP: begin
                state_next = hit ? bste_pkg::ST_RESP : bste_pkg::ST_ADV_FAIL;
            end
            bste_pkg::ST_ADV_FAIL: begin
                state_next = (banded_reg && (first_c + CW'(4) < n_c)) ? bste_pkg::ST_BAND_BRT
                                                                       : bste_pkg::ST_RESP;
            end
            bste_pkg::ST_BAND_BRT: state_next = bste_pkg::ST_SRCH;
            bste_pkg::ST_SRCH: begin
                state_next = (cnt_reg == '0) ? bste_pkg::ST_SRCH_END : bste_pkg::ST_SRCH_CMP;
            end
            bste_pkg::ST_SRCH_CMP: state_next = bste_pkg::ST_SRCH;
            bste_pkg::ST_SRCH_END: state_next = bste_pkg::ST_RESP;
            bste_pkg::ST_RESP:     state_next = out_free ? bste_pkg::ST_IDLE : bste_pkg::ST_RESP;
            default:               state_next = bste_pkg::ST_IDLE;
        endcase
    end

    // Handshake and RAM port control.
    always_comb begin
        s_ready     = (state_reg == bste_pkg::ST_IDLE);
        ram_wr_en   = accept && (s_data.operation == bste_pkg::OP_LOAD) && (addr_c < MAX_C);
        ram_rd_addr = '0;
        unique case (state_reg)
            bste_pkg::ST_BAND:     ram_rd_addr = band_idx[IDX_W-1:0];
            bste_pkg::ST_ADV_T:    ram_rd_addr = third_reg + IDX_W'(1);
            bste_pkg::ST_ADV_S:    ram_rd_addr = second_reg + IDX_W'(1);
            bste_pkg::ST_ADV_F:    ram_rd_addr = first_reg + IDX_W'(1);
            bste_pkg::ST_ADV_FAIL: ram_rd_addr = first_reg + IDX_W'(1);
            bste_pkg::ST_SRCH:     ram_rd_addr = mid[IDX_W-1:0];
            default:               ram_rd_addr = '0;
        endcase
    end

    // Datapath next values.
    always_comb begin
        first_next  = first_reg;
        second_next = second_reg;
        third_next  = third_reg;
        done_next   = done_reg;
        banded_next = banded_reg;
        limit_next  = limit_reg;
        lo_next     = lo_reg;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            bste_pkg::ST_IDLE: begin
                if (accept) begin
                    limit_next  = s_data.limit;
                    lo_next     = '0;
                    cnt_next    = n_c;
                    banded_next = (s_data.operation == bste_pkg::OP_BANDED);
                end
            end
            bste_pkg::ST_BAND: begin
                // Past the end of the table the dim limit is zero.
                if (!(band_idx < n_c)) begin
                    limit_next = '0;
                end
            end
            bste_pkg::ST_BAND_DIM: limit_next = ram_rd_data;
            bste_pkg::ST_ADV_T_CMP: begin
                if (hit) begin
                    third_next = third_reg + IDX_W'(1);
                    done_next  = 1'b0;
                end
            end
            bste_pkg::ST_ADV_S_CMP: begin
                if (hit) begin
                    second_next = second_reg + IDX_W'(1);
                    third_next  = second_reg + IDX_W'(2);
                    done_next   = 1'b0;
                end
            end
            bste_pkg::ST_ADV_F_CMP: begin
                if (hit) begin
                    first_next  = first_reg + IDX_W'(1);
                    second_next = first_reg + IDX_W'(2);
                    third_next  = first_reg + IDX_W'(3);
                    done_next   = 1'b0;
                end
            end
            bste_pkg::ST_ADV_FAIL: done_next = 1'b1;
            bste_pkg::ST_BAND_BRT: begin
                limit_next = ram_rd_data;
                lo_next    = '0;
                cnt_next   = n_c;
            end
            bste_pkg::ST_SRCH_CMP: begin
                if (ram_rd_data > limit_reg) begin
                    lo_next  = mid + CW'(1);
                    cnt_next = cnt_reg - half - CW'(1);
                end else begin
                    cnt_next = half;
                end
            end
            bste_pkg::ST_SRCH_END: begin
                if (lo_reg + CW'(3) > n_c) begin
                    done_next = 1'b1;
                end else begin
                    first_next  = lo_reg[IDX_W-1:0];
                    second_next = lo_reg[IDX_W-1:0] + IDX_W'(1);
                    third_next  = lo_reg[IDX_W-1:0] + IDX_W'(2);
                    done_next   = 1'b0;
                end
                // A band slide always leaves the walk open.
                if (banded_reg) begin
                    done_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bste_pkg::ST_IDLE;
            first_reg      <= IDX_W'(0);
            second_reg     <= IDX_W'(1);
            third_reg      <= IDX_W'(2);
            done_reg       <= 1'b0;
            banded_reg     <= 1'b0;
            star_count_reg <= bste_pkg::STAR_COUNT_RST;
            band_width_reg <= bste_pkg::BAND_WIDTH_RST;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            third_reg  <= third_next;
            done_reg   <= done_next;
            banded_reg <= banded_next;
            if (cfg_valid) begin
                if (cfg_index == bste_pkg::REG_STAR_COUNT) begin
                    star_count_reg <= cfg_data;
                end else if (cfg_index == bste_pkg::REG_BAND_WIDTH) begin
                    band_width_reg <= cfg_data;
                end
            end
            if (state_reg == bste_pkg::ST_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg <= limit_next;
        lo_reg    <= lo_next;
        cnt_reg   <= cnt_next;
        if (state_reg == bste_pkg::ST_RESP && out_free) begin
            m_data_reg.first_index  <= first_c[9:0];
            m_data_reg.second_index <= second_c[9:0];
            m_data_reg.third_index  <= third_c[9:0];
            m_data_reg.exhausted    <= done_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== sv/bste_ram.sv =====
// ----------------------------------------------------------------------------
// bste_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bste_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/bste_checker.sv =====
// ----------------------------------------------------------------------------
// bste_checker
// Port-level checks on the banded star triple enumerator, bound to the top.
// ----------------------------------------------------------------------------
module bste_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input bste_pkg::bste_out_t m_data
);

    // A stalled result keeps its payload until the transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result payload changed while stalled");

    // No result is presented straight after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Items are taken one at a time, so input ready drops after a transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second input taken while an item is in progress");

    // A presented triple is always strictly increasing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.first_index < m_data.second_index) &&
                    (m_data.second_index < m_data.third_index))
        else $error("triple out of order");

endmodule

bind banded_star_triple_enumerator bste_checker u_bste_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
